### hdl/iso_datetime_validator_defines.svh
// Assertion macros for the timestamp validator checker.
// Used only by idv_checker.sv; no other dependencies.
`ifndef ISO_DATETIME_VALIDATOR_DEFINES_SVH
`define ISO_DATETIME_VALIDATOR_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define IDV_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, not disabled by reset.
`define IDV_ASSERT_NEXT(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/idv_pkg.sv
// Shared constants and types for the ISO timestamp validator.
// No dependencies.
package idv_pkg;

  localparam int CHAR_W = 8;
  localparam int POS_W  = 5;
  localparam int FLD_W  = 7;

  localparam logic [POS_W-1:0] TS_LEN     = 5'd19;
  localparam logic [POS_W-1:0] POS_LAST   = 5'd18;
  localparam logic [POS_W-1:0] POS_DASH0  = 5'd4;
  localparam logic [POS_W-1:0] POS_DASH1  = 5'd7;
  localparam logic [POS_W-1:0] POS_TSEP   = 5'd10;
  localparam logic [POS_W-1:0] POS_COLON0 = 5'd13;
  localparam logic [POS_W-1:0] POS_COLON1 = 5'd16;
  localparam logic [POS_W-1:0] POS_YLO    = 5'd2;
  localparam logic [POS_W-1:0] POS_MON    = 5'd4;
  localparam logic [POS_W-1:0] POS_DAY    = 5'd7;
  localparam logic [POS_W-1:0] POS_HOUR   = 5'd10;
  localparam logic [POS_W-1:0] POS_MIN    = 5'd13;
  localparam logic [POS_W-1:0] POS_SEC    = 5'd16;

  localparam logic [CHAR_W-1:0] CHAR_DASH  = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_T     = 8'h54;
  localparam logic [CHAR_W-1:0] CHAR_COLON = 8'h3A;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

  // Year is held as two-digit halves: century part and year-in-century.
  typedef struct packed {
    logic [FLD_W-1:0] year_hi;
    logic [FLD_W-1:0] year_lo;
    logic [FLD_W-1:0] month;
    logic [FLD_W-1:0] day;
    logic [FLD_W-1:0] hour;
    logic [FLD_W-1:0] minute;
    logic [FLD_W-1:0] second;
  } idv_fields_t;

endpackage

### hdl/idv_if.sv
// Valid/ready channel interfaces for the timestamp validator.
// Depends on idv_pkg.
interface idv_in_if
  import idv_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              last_char;

  modport source (output valid, char_code, last_char, input ready);
  modport sink   (input valid, char_code, last_char, output ready);
endinterface

interface idv_out_if
  import idv_pkg::*;
  ();
  logic valid;
  logic ready;
  logic timestamp_ok;

  modport source (output valid, timestamp_ok, input ready);
  modport sink   (input valid, timestamp_ok, output ready);
endinterface

### hdl/idv_field_check.sv
// Calendar range check of the seven decoded timestamp fields.
// Depends on idv_pkg (idv_fields_t).
module idv_field_check
  import idv_pkg::*;
(
  input  idv_fields_t fields,
  output logic        fields_ok
);

  logic             leap;
  logic [FLD_W-1:0] mdays;
  logic             range_ok;

  // Fields are two decimal digits each, so year = 100*hi + lo.
  assign leap = (fields.year_lo == '0) ? (fields.year_hi[1:0] == 2'd0)
                                       : (fields.year_lo[1:0] == 2'd0);

  always_comb begin
    unique case (fields.month)
      7'd2:                      mdays = leap ? 7'd29 : 7'd28;
      7'd4, 7'd6, 7'd9, 7'd11:   mdays = 7'd30;
      default:                   mdays = 7'd31;
    endcase
  end

  assign range_ok = (fields.year_hi >= 7'd10) &&
                    (fields.month >= 7'd1) && (fields.month <= 7'd12) &&
                    (fields.day >= 7'd1) && (fields.day <= 7'd31) &&
                    (fields.hour <= 7'd23) &&
                    (fields.minute <= 7'd59) &&
                    (fields.second <= 7'd59);

  assign fields_ok = range_ok && (fields.day <= mdays);

endmodule

### hdl/iso_datetime_validator.sv
// Top level of the ISO 8601 timestamp validator (YYYY-MM-DDTHH:MM:SS).
// Depends on idv_pkg, idv_in_if, idv_out_if and idv_field_check.
//
// Usage:
//   in_ch  : one ASCII character per transfer, last_char marks the final one.
//   out_ch : one timestamp_ok bit per string, produced for the last character
//            only; other characters produce nothing.
//   Timing: a character is registered in the input register on its transfer;
//   the last one is then resolved into the output register, which presents
//   timestamp_ok; a full output register can hold it in the input register.
//   Throughput: one character per cycle except while stalled (below); the
//   parse is one compare/accumulate step between input and result registers.
//   Reset (rst_n low, synchronous): position, error flag and accumulators
//   clear, both channel registers empty. The block rearms after every last
//   character.
//   Stall: a pending result waits in the output register; characters keep
//   flowing until a second last character meets a full output register,
//   which then holds the input register and drops in_ch.ready.
module iso_datetime_validator
  import idv_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  idv_in_if.sink     in_ch,
  idv_out_if.source  out_ch
);

  logic              in_vld_r;
  logic [CHAR_W-1:0] char_r;
  logic              last_r;
  logic              proceed;

  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic              err_r, err_nxt;
  idv_fields_t       fld_r, fld_nxt;

  logic              out_vld_r;
  logic              out_ok_r;

  logic              is_digit;
  logic [3:0]        digit;
  logic              fields_ok;
  logic              ended_ok;

  function automatic logic [FLD_W-1:0] acc_digit(input logic [FLD_W-1:0] acc,
                                                 input logic [3:0] d);
    logic [FLD_W+3:0] sum;
    sum = {acc, 3'b000} + {2'b00, acc, 1'b0} + {{FLD_W{1'b0}}, d};
    return sum[FLD_W-1:0];
  endfunction

  assign proceed      = in_vld_r && (!last_r || !out_vld_r || out_ch.ready);
  assign in_ch.ready  = !in_vld_r || proceed;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      char_r <= in_ch.char_code;
      last_r <= in_ch.last_char;
    end
  end

  assign is_digit = (char_r >= CHAR_ZERO) && (char_r <= CHAR_NINE);
  assign digit    = char_r[3:0];

  always_comb begin
    err_nxt = err_r;
    fld_nxt = fld_r;
    if (pos_r >= TS_LEN) begin
      err_nxt = 1'b1;
    end else begin
      unique case (pos_r)
        POS_DASH0, POS_DASH1: begin
          if (char_r != CHAR_DASH) err_nxt = 1'b1;
        end
        POS_TSEP: begin
          if (char_r != CHAR_T) err_nxt = 1'b1;
        end
        POS_COLON0, POS_COLON1: begin
          if (char_r != CHAR_COLON) err_nxt = 1'b1;
        end
        default: begin
          if (!is_digit) begin
            err_nxt = 1'b1;
          end else begin
            priority if (pos_r < POS_YLO) fld_nxt.year_hi = acc_digit(fld_r.year_hi, digit);
            else if (pos_r < POS_MON)     fld_nxt.year_lo = acc_digit(fld_r.year_lo, digit);
            else if (pos_r < POS_DAY)     fld_nxt.month   = acc_digit(fld_r.month, digit);
            else if (pos_r < POS_HOUR)    fld_nxt.day     = acc_digit(fld_r.day, digit);
            else if (pos_r < POS_MIN)     fld_nxt.hour    = acc_digit(fld_r.hour, digit);
            else if (pos_r < POS_SEC)     fld_nxt.minute  = acc_digit(fld_r.minute, digit);
            else                          fld_nxt.second  = acc_digit(fld_r.second, digit);
          end
        end
      endcase
    end
    pos_nxt = (pos_r < TS_LEN) ? pos_r + 5'd1 : pos_r;
  end

  idv_field_check u_check (
    .fields    (fld_nxt),
    .fields_ok (fields_ok)
  );

  assign ended_ok = (pos_r == POS_LAST) && !err_nxt && fields_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      err_r <= 1'b0;
      fld_r <= '0;
    end else if (proceed) begin
      if (last_r) begin
        pos_r <= '0;
        err_r <= 1'b0;
        fld_r <= '0;
      end else begin
        pos_r <= pos_nxt;
        err_r <= err_nxt;
        fld_r <= fld_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (proceed && last_r) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proceed && last_r) begin
      out_ok_r <= ended_ok;
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.timestamp_ok = out_ok_r;

endmodule

### hdl/idv_checker.sv
// Port-level checks for iso_datetime_validator, attached by bind.
// Depends on iso_datetime_validator_defines.svh.
`include "iso_datetime_validator_defines.svh"

module idv_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic in_last,
  input logic out_valid,
  input logic out_ready,
  input logic out_ok
);

  `IDV_ASSERT_NOW(a_out_hold, clk, rst_n,
    $past(out_valid && !out_ready) && $past(rst_n),
    out_valid && $stable(out_ok), "result dropped or changed while stalled")
  `IDV_ASSERT_NOW(a_out_cause, clk, rst_n, $rose(out_valid),
    $past(in_valid && in_ready && in_last, 2),
    "result without a last-character transfer")
  `IDV_ASSERT_NOW(a_in_flow, clk, rst_n, !out_valid, in_ready,
    "input stalled with empty result register")
  `IDV_ASSERT_NEXT(a_rst_empty, clk, !rst_n, !out_valid, "result valid after reset")

endmodule

bind iso_datetime_validator idv_checker u_idv_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_last   (in_ch.last_char),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_ok    (out_ch.timestamp_ok)
);
